// ===== rtl/hrsp_pkg.sv =====
package hrsp_pkg;

  // Default request window in bytes; later bytes are passed but not parsed
  localparam int MAX_LEN_DEFAULT = 1024;

  localparam int HDR_LEN = 14;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_C     = 8'h43;

  // "Content-Length"
  localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{
    8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74,
    8'h2d, 8'h4c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68
  };

  // Method codes, also the bit index in the candidate mask
  typedef enum logic [1:0] {
    M_GET    = 2'd0,
    M_PUT    = 2'd1,
    M_POST   = 2'd2,
    M_DELETE = 2'd3
  } method_t;

  // One classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0]         data_byte;
    logic               last_byte;
    logic               beyond;      // position at or past the window
    logic [3:0]         cand_clear;  // methods this byte rules out
    logic               is_space;
    logic               is_c;
    logic               is_cr;
    logic               is_lf;
    logic [HDR_LEN-1:0] hdr_eq;      // byte equals header char at each index
    logic               ge3;         // position after this byte >= 3
    logic               ge4;
    logic               ge6;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t ent;
  } qpush_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } qhead_t;

  // Methods whose name disagrees with byte b at position idx (idx < 6)
  function automatic logic [3:0] method_mismatch(logic [2:0] idx, logic [7:0] b);
    logic [3:0] m;
    m = 4'b0000;
    case (idx)
      3'd0: begin
        m[M_GET]    = (b != 8'h47);
        m[M_PUT]    = (b != 8'h50);
        m[M_POST]   = (b != 8'h50);
        m[M_DELETE] = (b != 8'h44);
      end
      3'd1: begin
        m[M_GET]    = (b != 8'h45);
        m[M_PUT]    = (b != 8'h55);
        m[M_POST]   = (b != 8'h4f);
        m[M_DELETE] = (b != 8'h45);
      end
      3'd2: begin
        m[M_GET]    = (b != 8'h54);
        m[M_PUT]    = (b != 8'h54);
        m[M_POST]   = (b != 8'h53);
        m[M_DELETE] = (b != 8'h4c);
      end
      3'd3: begin
        m[M_POST]   = (b != 8'h54);
        m[M_DELETE] = (b != 8'h45);
      end
      3'd4: m[M_DELETE] = (b != 8'h54);
      3'd5: m[M_DELETE] = (b != 8'h45);
      default: m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/hrsp_req_if.sv =====
interface hrsp_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/hrsp_res_if.sv =====
interface hrsp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       url_valid;
  logic       body_valid;
  logic       request_done;
  logic [1:0] method;

  modport source (output valid, output byte_out, output url_valid, output body_valid,
                  output request_done, output method, input ready);
  modport sink   (input valid, input byte_out, input url_valid, input body_valid,
                  input request_done, input method, output ready);
endinterface

// ===== rtl/hrsp_front.sv =====
module hrsp_front #(
  parameter int MAX_LEN = hrsp_pkg::MAX_LEN_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  hrsp_req_if.sink           req,
  input  logic               full,
  output hrsp_pkg::qpush_t   qpush
);
  localparam int POS_W = $clog2(MAX_LEN + 1);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             beyond;
  logic [POS_W-1:0] pos_inc;
  logic             accept;

  assign req.ready = !full;
  assign accept    = req.valid && !full;

  assign beyond  = (pos >= POS_W'(MAX_LEN));
  assign pos_inc = beyond ? pos : pos + POS_W'(1);

  // Position counter, saturating at the window, cleared after the last word
  always_comb begin
    pos_next = pos;
    if (accept) begin
      pos_next = req.last_byte ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  // Classify the byte
  always_comb begin
    qpush.push               = accept;
    qpush.ent.data_byte      = req.data_byte;
    qpush.ent.last_byte      = req.last_byte;
    qpush.ent.beyond         = beyond;
    qpush.ent.cand_clear     = (pos < POS_W'(6)) ?
                               hrsp_pkg::method_mismatch(pos[2:0], req.data_byte) : 4'b0000;
    qpush.ent.is_space       = (req.data_byte == hrsp_pkg::CHAR_SPACE);
    qpush.ent.is_c           = (req.data_byte == hrsp_pkg::CHAR_C);
    qpush.ent.is_cr          = (req.data_byte == hrsp_pkg::CHAR_CR);
    qpush.ent.is_lf          = (req.data_byte == hrsp_pkg::CHAR_LF);
    for (int i = 0; i < hrsp_pkg::HDR_LEN; i++) begin
      qpush.ent.hdr_eq[i]    = (req.data_byte == hrsp_pkg::HDR_TEXT[i]);
    end
    qpush.ent.ge3            = (pos_inc >= POS_W'(3));
    qpush.ent.ge4            = (pos_inc >= POS_W'(4));
    qpush.ent.ge6            = (pos_inc >= POS_W'(6));
  end
endmodule

// ===== rtl/hrsp_queue.sv =====
module hrsp_queue (
  input  logic               clk,
  input  logic               rst,
  input  hrsp_pkg::qpush_t   qpush,
  output logic               full,
  output hrsp_pkg::qhead_t   head,
  input  logic               pop
);
  hrsp_pkg::entry_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == 2'd2);
  assign do_push    = qpush.push && !full;
  assign do_pop     = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.ent   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= qpush.ent;
    end
  end
endmodule

// ===== rtl/hrsp_back.sv =====
module hrsp_back (
  input  logic               clk,
  input  logic               rst,
  input  hrsp_pkg::qhead_t   head,
  output logic               pop,
  hrsp_res_if.source         res
);
  logic [3:0] cand, cand_next;
  logic [1:0] space_count, space_count_next;
  logic [3:0] hdr_prog, hdr_prog_next;
  logic       hdr_seen, hdr_seen_next;
  logic [2:0] blank_prog, blank_prog_next;
  logic       in_body, in_body_next;

  logic                 url_v;
  logic                 body_v;
  hrsp_pkg::method_t    meth;
  hrsp_pkg::entry_t     ent;
  logic                 blank_hit;

  assign ent = head.ent;
  assign pop = head.valid && (!res.valid || res.ready);

  // Parser state update for the word at the queue head
  always_comb begin
    cand_next        = cand;
    space_count_next = space_count;
    hdr_prog_next    = hdr_prog;
    hdr_seen_next    = hdr_seen;
    blank_prog_next  = blank_prog;
    in_body_next     = in_body;
    url_v            = 1'b0;
    body_v           = 1'b0;
    meth             = hrsp_pkg::M_GET;
    blank_hit        = blank_prog[0] ? ent.is_lf : ent.is_cr;

    if (pop) begin
      if (!ent.beyond) begin
        url_v     = (space_count == 2'd1) && !ent.is_space;
        body_v    = in_body;
        cand_next = cand & ~ent.cand_clear;
        if (ent.is_space && space_count != 2'd2) begin
          space_count_next = space_count + 2'd1;
        end
        if (!hdr_seen) begin
          if (ent.hdr_eq[hdr_prog]) hdr_prog_next = hdr_prog + 4'd1;
          else                      hdr_prog_next = ent.is_c ? 4'd1 : 4'd0;
          if (hdr_prog_next == 4'(hrsp_pkg::HDR_LEN)) begin
            hdr_seen_next = 1'b1;
            hdr_prog_next = 4'd0;
          end
        end else if (!in_body) begin
          if (blank_hit) blank_prog_next = blank_prog + 3'd1;
          else           blank_prog_next = ent.is_cr ? 3'd1 : 3'd0;
          if (blank_prog_next == 3'd4) begin
            in_body_next    = 1'b1;
            blank_prog_next = 3'd0;
          end
        end
      end

      if (ent.last_byte) begin
        // First full match in order GET, POST, PUT, DELETE
        if (cand_next[hrsp_pkg::M_GET] && ent.ge3)          meth = hrsp_pkg::M_GET;
        else if (cand_next[hrsp_pkg::M_POST] && ent.ge4)    meth = hrsp_pkg::M_POST;
        else if (cand_next[hrsp_pkg::M_PUT] && ent.ge3)     meth = hrsp_pkg::M_PUT;
        else if (cand_next[hrsp_pkg::M_DELETE] && ent.ge6)  meth = hrsp_pkg::M_DELETE;
        else                                                meth = hrsp_pkg::M_GET;
        cand_next        = 4'hf;
        space_count_next = 2'd0;
        hdr_prog_next    = 4'd0;
        hdr_seen_next    = 1'b0;
        blank_prog_next  = 3'd0;
        in_body_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand        <= 4'hf;
      space_count <= 2'd0;
      hdr_prog    <= 4'd0;
      hdr_seen    <= 1'b0;
      blank_prog  <= 3'd0;
      in_body     <= 1'b0;
    end else begin
      cand        <= cand_next;
      space_count <= space_count_next;
      hdr_prog    <= hdr_prog_next;
      hdr_seen    <= hdr_seen_next;
      blank_prog  <= blank_prog_next;
      in_body     <= in_body_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (pop) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.byte_out     <= ent.data_byte;
      res.url_valid    <= url_v;
      res.body_valid   <= body_v;
      res.request_done <= ent.last_byte;
      res.method       <= meth;
    end
  end

  a_hdr_range: assert property (@(posedge clk) disable iff (rst)
    hdr_prog < 4'(hrsp_pkg::HDR_LEN))
    else $error("header match progress out of range");

  a_blank_range: assert property (@(posedge clk) disable iff (rst)
    blank_prog < 3'd4)
    else $error("blank line progress out of range");

  a_body_after_hdr: assert property (@(posedge clk) disable iff (rst)
    in_body |-> hdr_seen)
    else $error("body flagged before header seen");

  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    (pop && ent.last_byte) |=> (cand == 4'hf && space_count == 2'd0 && !hdr_seen && !in_body))
    else $error("parser state not cleared after last word");

  a_meth_only_done: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.request_done) |-> (res.method == 2'd0))
    else $error("method reported on a word that does not end a request");
endmodule

// ===== rtl/http_request_stream_parser.sv =====
// An accepted word is stored in the queue and then in the output register that drives res.
// Throughput: one word per cycle while res.ready is high; the two-entry queue and the
// output register let either side stall on its own. While the queue is full req.ready
// is low, and it comes back the cycle after the back end takes a word from it.
// Reset (rst, synchronous, active high) empties the queue and output register
// and puts the parser in its start-of-request state; no clearing pass.
module http_request_stream_parser #(
  parameter int MAX_LEN = hrsp_pkg::MAX_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  hrsp_req_if.sink   req,
  hrsp_res_if.source res
);
  hrsp_pkg::qpush_t qpush;
  hrsp_pkg::qhead_t head;
  logic             full;
  logic             pop;

  hrsp_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .full  (full),
    .qpush (qpush)
  );

  hrsp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .qpush (qpush),
    .full  (full),
    .head  (head),
    .pop   (pop)
  );

  hrsp_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .res  (res)
  );
endmodule

// ===== sim/tb_http_request_stream_parser.sv =====
module tb_http_request_stream_parser;

  // Narrow window so that requests regularly run past it
  localparam int WINDOW = 64;
  localparam int RANDOM_WORDS = 1700;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } req_word_t;

  typedef struct packed {
    logic [7:0]         data;
    logic               url;
    logic               body;
    logic               done;
    hrsp_pkg::method_t  meth;
  } parse_res_t;

  logic clk;
  logic rst;

  hrsp_req_if req_bus ();
  hrsp_res_if res_bus ();

  http_request_stream_parser #(.MAX_LEN(WINDOW)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .res (res_bus)
  );

  // Method names indexed by method code
  string method_name [4] = '{"GET", "PUT", "POST", "DELETE"};
  // Priority when several names still match
  hrsp_pkg::method_t method_order [4] = '{hrsp_pkg::M_GET, hrsp_pkg::M_POST,
                                          hrsp_pkg::M_PUT, hrsp_pkg::M_DELETE};

  logic [7:0] build_q [$];
  req_word_t  pending [$];
  parse_res_t expected_res [$];

  int   total_words;
  int   words_taken;
  bit   word_took;
  int   errors;
  int   results_seen;

  // Parser state as seen by the predictor
  int         pos_q;
  logic [3:0] cand_q;
  int         spaces_q;
  int         hdr_prog_q;
  logic       hdr_seen_q;
  int         blank_prog_q;
  logic       body_q;

  // Coverage tallies
  int n_reqs;
  int n_url;
  int n_body;
  int n_beyond;
  int meth_hits [4];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_parser();
    pos_q        = 0;
    cand_q       = 4'hf;
    spaces_q     = 0;
    hdr_prog_q   = 0;
    hdr_seen_q   = 1'b0;
    blank_prog_q = 0;
    body_q       = 1'b0;
  endfunction

  // Classify one byte and advance the parser state
  function automatic parse_res_t parse_step(logic [7:0] ch, logic last);
    parse_res_t r;
    logic [7:0] want;
    bit         found;
    r      = '0;
    r.data = ch;
    r.done = last;
    r.meth = hrsp_pkg::M_GET;
    if (pos_q < WINDOW) begin
      r.url  = (spaces_q == 1) && (ch != hrsp_pkg::CHAR_SPACE);
      r.body = body_q;
      for (int m = 0; m < 4; m++) begin
        if (pos_q < method_name[m].len() && method_name[m][pos_q] != ch) cand_q[m] = 1'b0;
      end
      if (ch == hrsp_pkg::CHAR_SPACE && spaces_q < 2) spaces_q++;
      if (!hdr_seen_q) begin
        // header text has no self-overlap, so a miss restarts at C or zero
        if (ch == hrsp_pkg::HDR_TEXT[hdr_prog_q]) hdr_prog_q++;
        else hdr_prog_q = (ch == hrsp_pkg::CHAR_C) ? 1 : 0;
        if (hdr_prog_q >= hrsp_pkg::HDR_LEN) begin
          hdr_seen_q = 1'b1;
          hdr_prog_q = 0;
        end
      end else if (!body_q) begin
        want = blank_prog_q[0] ? hrsp_pkg::CHAR_LF : hrsp_pkg::CHAR_CR;
        if (ch == want) blank_prog_q++;
        else blank_prog_q = (ch == hrsp_pkg::CHAR_CR) ? 1 : 0;
        if (blank_prog_q >= 4) begin
          body_q       = 1'b1;
          blank_prog_q = 0;
        end
      end
      pos_q++;
    end else begin
      n_beyond++;
    end
    if (r.url) n_url++;
    if (r.body) n_body++;
    if (last) begin
      found = 1'b0;
      foreach (method_order[i]) begin
        if (!found && cand_q[method_order[i]] &&
            pos_q >= method_name[method_order[i]].len()) begin
          r.meth = method_order[i];
          found  = 1'b1;
        end
      end
      meth_hits[r.meth]++;
      n_reqs++;
      clear_parser();
    end
    return r;
  endfunction

  // Request assembly helpers
  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) build_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_char();
    string alpha;
    alpha = "GETPOSUDLCntehgl-: \r\n";
    if ($urandom_range(0, 99) < 60) return alpha[$urandom_range(0, alpha.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void commit_request();
    req_word_t w;
    foreach (build_q[i]) begin
      w.data = build_q[i];
      w.last = (i == build_q.size() - 1);
      pending.push_back(w);
    end
    build_q.delete();
  endfunction

  // One random request: mostly well-formed, some broken, some noise
  function automatic void build_request();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      n = $urandom_range(0, 5);
      if (n < 4) push_text(method_name[n]);
      else for (int i = $urandom_range(1, 7); i > 0; i--) build_q.push_back(pick_char());
      build_q.push_back(hrsp_pkg::CHAR_SPACE);
      for (int i = $urandom_range(0, 7); i > 0; i--) begin
        if ($urandom_range(0, 9) == 0) build_q.push_back(hrsp_pkg::CHAR_SPACE);
        else build_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
      end
      if ($urandom_range(0, 3) != 0) push_text(" HTTP/1.1");
      push_text("\r\n");
      if ($urandom_range(0, 2) == 0) push_text("Host: h\r\n");
      // blank line ahead of the header must not open the body
      if ($urandom_range(0, 9) == 0) push_text("\r\n");
      case ($urandom_range(0, 7))
        0, 1, 2, 3: push_text("Content-Length: ");
        4:          push_text("CContent-Length: ");
        5:          push_text("Content-Lenght: ");
        6:          push_text("content-length: ");
        default:    push_text("X: ");
      endcase
      for (int i = $urandom_range(1, 2); i > 0; i--) begin
        build_q.push_back(8'($urandom_range(8'h30, 8'h39)));
      end
      push_text("\r\n");
      if ($urandom_range(0, 4) == 0) push_text("\r\r\n");
      push_text("\r\n");
      for (int i = $urandom_range(0, 12); i > 0; i--) begin
        if ($urandom_range(0, 1) == 0) build_q.push_back(8'($urandom_range(0, 255)));
        else build_q.push_back(pick_char());
      end
      // broken variants
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, build_q.size());
        while (build_q.size() > n) void'(build_q.pop_back());
      end
      if ($urandom_range(0, 99) < 10)
        build_q[$urandom_range(0, build_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(WINDOW - 2, WINDOW + 24)
                                       : $urandom_range(1, 20);
      for (int i = 0; i < n; i++) build_q.push_back(pick_char());
    end
    commit_request();
  endfunction

  function automatic int idle_pct(bit rx_side);
    if (words_taken < total_words / 3) return rx_side ? 64 : 32;
    if (words_taken < 2 * total_words / 3) return rx_side ? 32 : 64;
    return 0;
  endfunction

  task automatic check_field(string fld, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
      errors++;
    end
  endtask

  // Sender: offer the next word at the falling edge, hold it until taken
  always @(negedge clk) begin
    if (rst) begin
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
    end else if (!req_bus.valid || word_took) begin
      if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
        req_bus.valid     <= 1'b1;
        req_bus.data_byte <= pending[0].data;
        req_bus.last_byte <= pending[0].last;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Accepted input word: predict its result
  always @(posedge clk) begin
    word_took = !rst && req_bus.valid && req_bus.ready;
    if (word_took) begin
      expected_res.push_back(parse_step(req_bus.data_byte, req_bus.last_byte));
      void'(pending.pop_front());
      words_taken++;
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    res_bus.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
  end

  // Result checker
  always @(posedge clk) begin
    parse_res_t exp_r;
    if (!rst && res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result word, byte_out %0d", $time, res_bus.byte_out);
        errors++;
      end else begin
        exp_r = expected_res.pop_front();
        check_field("byte_out", int'(exp_r.data), int'(res_bus.byte_out));
        check_field("url_valid", int'(exp_r.url), int'(res_bus.url_valid));
        check_field("body_valid", int'(exp_r.body), int'(res_bus.body_valid));
        check_field("request_done", int'(exp_r.done), int'(res_bus.request_done));
        check_field("method", int'(exp_r.meth), int'(res_bus.method));
      end
    end
  end

  // Watchdog
  initial begin
    #4000000;
    $display("[http_request_stream_parser] ERROR");
    $finish;
  end

  initial begin
    int first_random;
    clk               = 1'b0;
    rst               = 1'b1;
    words_taken       = 0;
    errors            = 0;
    results_seen      = 0;
    n_reqs            = 0;
    n_url             = 0;
    n_body            = 0;
    n_beyond          = 0;
    foreach (meth_hits[i]) meth_hits[i] = 0;
    clear_parser();

    // Directed: each method, too-short names, byte extremes, URL between spaces
    push_text("GET");
    commit_request();
    push_text("PUT a b");
    commit_request();
    push_text("POST");
    commit_request();
    push_text("DELETE");
    commit_request();
    push_text("POS");
    commit_request();
    build_q.push_back(8'h00);
    commit_request();
    build_q.push_back(8'hff);
    commit_request();

    first_random = pending.size();
    while (pending.size() - first_random < RANDOM_WORDS) build_request();
    total_words = pending.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || expected_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d requests in %0d words: %0d URL bytes, %0d body bytes,",
             n_reqs, words_taken, n_url, n_body);
    $display("%0d past window; methods GET %0d, PUT %0d, POST %0d, DELETE %0d; %0d mismatches",
             n_beyond, meth_hits[hrsp_pkg::M_GET], meth_hits[hrsp_pkg::M_PUT],
             meth_hits[hrsp_pkg::M_POST], meth_hits[hrsp_pkg::M_DELETE], errors);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("[http_request_stream_parser] OK");
    end else begin
      $display("[http_request_stream_parser] ERROR");
    end
    $finish;
  end

endmodule

// ===== http_request_stream_parser.f =====
rtl/hrsp_pkg.sv
rtl/hrsp_req_if.sv
rtl/hrsp_res_if.sv
rtl/hrsp_front.sv
rtl/hrsp_queue.sv
rtl/hrsp_back.sv
rtl/http_request_stream_parser.sv
sim/tb_http_request_stream_parser.sv
